>>> src/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

  localparam int SAMPLE_W = 24;
  localparam int RAW_W    = 32;
  localparam int PHASE_W  = 21;
  localparam int FRAC_W   = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int CNT_W    = 6;

  localparam logic [PHASE_W-1:0] PH_ONE   = PHASE_W'(1) << FRAC_W;
  localparam logic [PHASE_W-1:0] STEP_MAX = PHASE_W'(1) << (FRAC_W + 4);
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(63);

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_STEP = 2'd0;
  localparam logic [1:0] CFG_FMT  = 2'd1;
  localparam logic [1:0] CFG_CHAN = 2'd2;

  // Sample format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  typedef struct packed {
    logic prime;    // first frame: store it as previous, no output
    logic capture;  // store current frame, clear output count
    logic skip;     // phase already past one: drop frame, step phase back
    logic mul;      // form the two products for the current phase
    logic load;     // write the output word, advance phase
  } lir_cmd_t;

  typedef struct packed {
    logic primed;
    logic phase_ge_one;
    logic out_free;
    logic last;
  } lir_sts_t;

endpackage

>>> src/linear_interp_resampler.sv
`timescale 1ns / 1ps

// Linear-interpolation resampler for mono or stereo audio frames.
// Input channel: one word per frame (raw_left, raw_right), taken on
// in_valid && in_ready. Raw samples are normalized to signed Q1.23 by
// sample_format. Output channel: interpolated frames on out_valid &&
// out_ready; last_of_run marks the final word caused by one input frame.
// Configuration channel: cfg_index selects step_ratio (0), sample_format
// (1) or channel_count (2); cfg_ready is always high. Write it only while
// the block is idle.
// Sequence: a frame is taken in ST_IDLE. Each output word then passes
// through ST_CHECK, which forms the products, and ST_LOAD, which loads the
// output register, up to a cap of 64 words per frame. A frame yielding
// none returns from ST_CHECK straight to ST_IDLE. The next frame is
// accepted as soon as the last word of the previous one sits in the output
// register. The very first frame after reset only primes the history.
// Reset clears the phase, the previous frame and the primed flag, and loads
// a unit step, 16-bit format and stereo. When the receiver stalls, the
// output register holds its word and the sequencer waits in place.
module linear_interp_resampler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lir_pkg::RAW_W-1:0]     raw_left,
  input  logic signed [lir_pkg::RAW_W-1:0]     raw_right,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0]  out_left,
  output logic signed [lir_pkg::SAMPLE_W-1:0]  out_right,
  output logic                                 last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [lir_pkg::RAW_W-1:0]            cfg_data
);
  import lir_pkg::*;

  lir_cmd_t cmd;
  lir_sts_t sts;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lir_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .raw_left    (raw_left),
    .raw_right   (raw_right),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_left    (out_left),
    .out_right   (out_right),
    .last_of_run (last_of_run)
  );

endmodule

>>> src/lir_ctrl.sv
`timescale 1ns / 1ps

module lir_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lir_pkg::lir_sts_t sts,
  output lir_pkg::lir_cmd_t cmd
);
  import lir_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_LOAD  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!sts.primed) begin
            cmd.prime = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.phase_ge_one) begin
          cmd.skip   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = sts.last ? ST_IDLE : ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/lir_dp.sv
`timescale 1ns / 1ps

module lir_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lir_pkg::lir_cmd_t                    cmd,
  output lir_pkg::lir_sts_t                    sts,
  input  logic                                 cfg_valid,
  input  logic [1:0]                           cfg_index,
  input  logic [lir_pkg::RAW_W-1:0]            cfg_data,
  input  logic signed [lir_pkg::RAW_W-1:0]     raw_left,
  input  logic signed [lir_pkg::RAW_W-1:0]     raw_right,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0]  out_left,
  output logic signed [lir_pkg::SAMPLE_W-1:0]  out_right,
  output logic                                 last_of_run
);
  import lir_pkg::*;

  logic [PHASE_W-1:0] step_ratio;
  logic [1:0]         sample_format;
  logic [1:0]         channel_count;

  logic signed [SAMPLE_W-1:0] prev_left, prev_right;
  logic signed [SAMPLE_W-1:0] cur_left, cur_right;
  logic signed [SAMPLE_W-1:0] norm_left, norm_right;
  logic [PHASE_W-1:0]         phase;
  logic                       primed;
  logic [CNT_W-1:0]           cnt;
  logic signed [PROD_W-1:0]   prod_left, prod_right;

  logic [PHASE_W-1:0]       step;
  logic [PHASE_W:0]         phase_sum;
  logic [PHASE_W-1:0]       phase_next;
  logic signed [DIFF_W-1:0] diff_left, diff_right;
  logic signed [FRAC_W:0]   ph_mult;
  logic                     last;

  function automatic logic [SAMPLE_W-1:0] normalize(input logic [1:0] fmt,
                                                    input logic [RAW_W-1:0] raw);
    logic [SAMPLE_W-1:0] res;
    case (fmt)
      FMT_U8:  res = {~raw[7], raw[6:0], {(SAMPLE_W - 8){1'b0}}};
      FMT_S16: res = {raw[15:0], {(SAMPLE_W - 16){1'b0}}};
      FMT_S32: res = raw[RAW_W-1 -: SAMPLE_W];
      default: res = '0;
    endcase
    return res;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= PH_ONE;
      sample_format <= FMT_S16;
      channel_count <= 2'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP: step_ratio    <= cfg_data[PHASE_W-1:0];
        CFG_FMT:  sample_format <= cfg_data[1:0];
        CFG_CHAN: channel_count <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (step_ratio == '0) begin
      step = PHASE_W'(1);
    end else if (step_ratio > STEP_MAX) begin
      step = STEP_MAX;
    end else begin
      step = step_ratio;
    end
  end

  assign norm_left  = $signed(normalize(sample_format, raw_left));
  assign norm_right = $signed(normalize(sample_format, raw_right));

  assign diff_left  = DIFF_W'(cur_left) - DIFF_W'(prev_left);
  assign diff_right = DIFF_W'(cur_right) - DIFF_W'(prev_right);
  assign ph_mult    = $signed({1'b0, phase[FRAC_W-1:0]});

  assign phase_sum = {1'b0, phase} + {1'b0, step};
  assign last      = (phase_sum >= {1'b0, PH_ONE}) || (cnt == CNT_LAST);

  always_comb begin
    if (!last) begin
      phase_next = phase_sum[PHASE_W-1:0];
    end else if (phase_sum >= {1'b0, PH_ONE}) begin
      phase_next = phase_sum[PHASE_W-1:0] - PH_ONE;
    end else begin
      // output cap hit below one: the rest of the run is dropped
      phase_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      phase      <= '0;
      prev_left  <= '0;
      prev_right <= '0;
    end else begin
      if (cmd.prime) begin
        primed     <= 1'b1;
        prev_left  <= norm_left;
        prev_right <= norm_right;
      end
      if (cmd.skip) begin
        phase      <= phase - PH_ONE;
        prev_left  <= cur_left;
        prev_right <= cur_right;
      end
      if (cmd.load) begin
        phase <= phase_next;
        if (last) begin
          prev_left  <= cur_left;
          prev_right <= cur_right;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_left  <= norm_left;
      cur_right <= norm_right;
    end
    if (cmd.mul) begin
      prod_left  <= PROD_W'(diff_left * ph_mult);
      prod_right <= PROD_W'(diff_right * ph_mult);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_left    <= prev_left + prod_left[FRAC_W +: SAMPLE_W];
      out_right   <= channel_count[1] ? prev_right + prod_right[FRAC_W +: SAMPLE_W] : '0;
      last_of_run <= last;
    end
  end

  assign sts.primed       = primed;
  assign sts.phase_ge_one = phase >= PH_ONE;
  assign sts.out_free     = !out_valid || out_ready;
  assign sts.last         = last;

endmodule
